### src/tcpu_pkg.sv
package tcpu_pkg;

  localparam int MEM_DEPTH = 256;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // opcodes live in the upper nibble of the instruction byte
  localparam logic [3:0] OP_ADD   = 4'b0111;
  localparam logic [3:0] OP_SUB   = 4'b0001;
  localparam logic [3:0] OP_LOAD  = 4'b0010;
  localparam logic [3:0] OP_STORE = 4'b0011;
  localparam logic [3:0] OP_SKIP  = 4'b0100;
  localparam logic [3:0] OP_JALR  = 4'b0101;

  // shift-left-insert when the top two bits are set
  localparam logic [1:0] SLI_TOP = 2'b11;

  // skip flavors in the rs field
  localparam logic [1:0] SKIP_Z  = 2'b00;
  localparam logic [1:0] SKIP_NZ = 2'b01;

  localparam logic [7:0] HALT_WORD = 8'h01;

  localparam logic [ADDR_W-1:0] RESULT_ADDR = ADDR_W'(MEM_DEPTH - 1);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EXEC  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] load_addr;
    logic [7:0] load_data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] pc_after;
    logic [7:0] executed_word;
    logic [7:0] reg_a;
    logic [7:0] reg_b;
    logic [7:0] reg_c;
    logic [7:0] reg_d;
    logic [7:0] result_byte;
    logic       halt_seen;
  } rsp_t;

  // effects of one decoded instruction
  typedef struct packed {
    logic              reg_we;
    logic [1:0]        reg_idx;
    logic [7:0]        reg_val;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_val;
    logic              res_we;
    logic [7:0]        res_val;
    logic [7:0]        pc_next;
    logic              is_load;
    logic              halt;
  } exec_t;

endpackage

### src/tcpu_mem.sv
module tcpu_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [tcpu_pkg::ADDR_W-1:0]   waddr,
  input  logic [7:0]                    wdata,
  input  logic                          res_we,
  input  logic [7:0]                    res_val,
  input  logic                          re,
  input  logic [tcpu_pkg::ADDR_W-1:0]   raddr,
  output logic [7:0]                    rdata,
  output logic [7:0]                    byte_hi
);

  logic [7:0]                     mem [tcpu_pkg::MEM_DEPTH];
  logic [tcpu_pkg::MEM_DEPTH-1:0] vld;
  logic [7:0]                     rd_q;
  logic [7:0]                     fwd_data_q;
  logic                           fwd_q;
  logic                           vld_q;
  logic                           hi_q;
  logic [7:0]                     hi_byte;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q       <= mem[raddr];
      fwd_data_q <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      hi_byte <= '0;
      fwd_q   <= 1'b0;
      vld_q   <= 1'b0;
      hi_q    <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (res_we) begin
        hi_byte <= res_val;
      end else if (we && waddr == tcpu_pkg::RESULT_ADDR) begin
        hi_byte <= wdata;
      end
      if (re) begin
        fwd_q <= we && (waddr == raddr);
        vld_q <= vld[raddr];
        hi_q  <= (raddr == tcpu_pkg::RESULT_ADDR);
      end
    end
  end

  // top byte is kept in its own register; never-written entries read zero
  assign rdata   = hi_q  ? hi_byte    :
                   fwd_q ? fwd_data_q :
                   vld_q ? rd_q       : 8'h00;
  assign byte_hi = hi_byte;

endmodule

### src/tcpu_exec.sv
module tcpu_exec (
  input  logic [7:0]      word,
  input  logic [7:0]      pc,
  input  logic [3:0][7:0] regs,
  output tcpu_pkg::exec_t ex
);

  logic [3:0] op;
  logic [1:0] rd;
  logic [1:0] rs;
  logic [7:0] vd;
  logic [7:0] vs;
  logic [7:0] pc_inc;
  logic [7:0] alu;

  assign op     = word[7:4];
  assign rd     = word[3:2];
  assign rs     = word[1:0];
  assign vd     = regs[rd];
  assign vs     = regs[rs];
  assign pc_inc = pc + 8'd1;

  always_comb begin
    alu           = 8'h00;
    ex            = '0;
    ex.reg_idx    = rd;
    ex.mem_addr   = tcpu_pkg::ADDR_W'(vs);
    ex.mem_val    = vd;
    ex.pc_next    = pc_inc;
    priority if (op == tcpu_pkg::OP_ADD || op == tcpu_pkg::OP_SUB) begin
      alu        = (op == tcpu_pkg::OP_ADD) ? vd + vs : vd - vs;
      ex.reg_we  = 1'b1;
      ex.reg_val = alu;
      ex.res_we  = 1'b1;
      ex.res_val = alu;
    end else if (op == tcpu_pkg::OP_LOAD) begin
      ex.is_load = 1'b1;
    end else if (op == tcpu_pkg::OP_STORE) begin
      ex.mem_we  = 1'b1;
      ex.res_we  = 1'b1;
      ex.res_val = vd;
    end else if (op == tcpu_pkg::OP_SKIP) begin
      if ((rs == tcpu_pkg::SKIP_Z && vd == 8'h00) ||
          (rs == tcpu_pkg::SKIP_NZ && vd != 8'h00)) begin
        ex.pc_next = pc + 8'd2;
        ex.res_we  = 1'b1;
        ex.res_val = vd;
      end
    end else if (op == tcpu_pkg::OP_JALR) begin
      ex.reg_we  = 1'b1;
      ex.reg_val = pc_inc;
      ex.pc_next = vs;
      ex.res_we  = 1'b1;
      ex.res_val = pc_inc;
    end else if (word[7:6] == tcpu_pkg::SLI_TOP) begin
      alu        = {vd[3:0], word[5:4], word[1:0]};
      ex.reg_we  = 1'b1;
      ex.reg_val = alu;
      ex.res_we  = 1'b1;
      ex.res_val = alu;
    end else if (word == tcpu_pkg::HALT_WORD) begin
      ex.halt = 1'b1;
    end else begin
      ex.pc_next = pc_inc;
    end
  end

endmodule

### src/tiny_8bit_cpu_step.sv
// path: an instruction result passes the skid register, the memory read register and
// the result register; a load adds the operand read, a memory write skips the read
// throughput: one instruction per cycle back to back while results are not stalled;
// a load holds the single read port of the unified memory; a memory write waits for idle
// reset (synchronous): clears pc, registers and the per-byte valid bits, so memory
// reads zero at once with no clearing pass
module tiny_8bit_cpu_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  tcpu_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output tcpu_pkg::rsp_t rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_t;

  state_t          state;
  state_t          state_next;

  // input skid register
  tcpu_pkg::cmd_t  cmd_q;
  logic            cmd_full;

  // architectural state
  logic [7:0]      pc;
  logic [7:0]      pc_next;
  logic [3:0][7:0] regs;
  logic [3:0][7:0] regs_next;

  // instruction byte held while a load waits for its data
  logic [7:0]      word_q;

  tcpu_pkg::exec_t ex;
  tcpu_pkg::rsp_t  rsp_next;

  logic            out_free;
  logic            finish_exec;
  logic            finish_load;
  logic            finish_wr;
  logic            core_free;
  logic            start_exec;
  logic            take;

  // memory port signals
  logic                        mem_we;
  logic [tcpu_pkg::ADDR_W-1:0] mem_waddr;
  logic [7:0]                  mem_wdata;
  logic                        res_we;
  logic [7:0]                  res_val;
  logic                        mem_re;
  logic [tcpu_pkg::ADDR_W-1:0] mem_raddr;
  logic [7:0]                  rvalue;
  logic [7:0]                  byte_hi;
  logic [7:0]                  byte_hi_next;

  tcpu_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .res_we  (res_we),
    .res_val (res_val),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata   (rvalue),
    .byte_hi (byte_hi)
  );

  // decode the fetched byte straight off the memory read register
  tcpu_exec u_exec (
    .word (rvalue),
    .pc   (pc),
    .regs (regs),
    .ex   (ex)
  );

  // an item may only complete when the result register can take it
  assign out_free    = !rsp_valid || rsp_ready;
  assign finish_exec = (state == ST_EXEC) && !ex.is_load && out_free;
  assign finish_load = (state == ST_LOAD) && out_free;
  assign finish_wr   = (state == ST_IDLE) && cmd_full &&
                       (cmd_q.action == tcpu_pkg::ACT_WRITE) && out_free;

  // next fetch may issue in the same cycle an instruction retires
  assign core_free  = (state == ST_IDLE) || finish_exec || finish_load;
  assign start_exec = core_free && cmd_full && (cmd_q.action == tcpu_pkg::ACT_EXEC);
  assign take       = start_exec || finish_wr;
  assign cmd_ready  = !cmd_full || take;

  // retiring values of pc and registers
  always_comb begin
    regs_next = regs;
    pc_next   = pc;
    if (finish_exec) begin
      pc_next = ex.pc_next;
      if (ex.reg_we) begin
        regs_next[ex.reg_idx] = ex.reg_val;
      end
    end else if (finish_load) begin
      pc_next              = pc + 8'd1;
      regs_next[word_q[3:2]] = rvalue;
    end
  end

  // write port: loader transactions or stores, never both in one cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ex.mem_addr;
    mem_wdata = ex.mem_val;
    if (finish_wr) begin
      mem_we    = 1'b1;
      mem_waddr = tcpu_pkg::ADDR_W'(cmd_q.load_addr);
      mem_wdata = cmd_q.load_data;
    end else if (finish_exec) begin
      mem_we = ex.mem_we;
    end
  end

  // top memory byte copy of each result
  always_comb begin
    res_we  = 1'b0;
    res_val = ex.res_val;
    if (finish_exec) begin
      res_we = ex.res_we;
    end else if (finish_load) begin
      res_we  = 1'b1;
      res_val = rvalue;
    end
  end

  // read port: instruction fetch at the new pc, or load operand
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = tcpu_pkg::ADDR_W'(pc_next);
    if (start_exec) begin
      mem_re = 1'b1;
    end else if (state == ST_EXEC && ex.is_load) begin
      mem_re    = 1'b1;
      mem_raddr = ex.mem_addr;
    end
  end

  assign byte_hi_next = res_we ? res_val :
                        (mem_we && mem_waddr == tcpu_pkg::RESULT_ADDR) ? mem_wdata :
                        byte_hi;

  always_comb begin
    rsp_next.pc_after      = pc_next;
    rsp_next.executed_word = finish_exec ? rvalue : finish_load ? word_q : 8'h00;
    rsp_next.reg_a         = regs_next[0];
    rsp_next.reg_b         = regs_next[1];
    rsp_next.reg_c         = regs_next[2];
    rsp_next.reg_d         = regs_next[3];
    rsp_next.result_byte   = byte_hi_next;
    rsp_next.halt_seen     = finish_exec && ex.halt;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_exec) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (ex.is_load) begin
          state_next = ST_LOAD;
        end else if (finish_exec) begin
          state_next = start_exec ? ST_EXEC : ST_IDLE;
        end
      end
      ST_LOAD: begin
        if (finish_load) begin
          state_next = start_exec ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cmd_full  <= 1'b0;
      rsp_valid <= 1'b0;
      pc        <= 8'h00;
      regs      <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      regs  <= regs_next;

      // input transaction lands in the skid register
      if (cmd_valid && cmd_ready) begin
        cmd_full <= 1'b1;
        cmd_q    <= cmd;
      end else if (take) begin
        cmd_full <= 1'b0;
      end

      if (state == ST_EXEC && ex.is_load) begin
        word_q <= rvalue;
      end

      // result register
      if (finish_exec || finish_load || finish_wr) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

### src/tcpu_checker.sv
module tcpu_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input tcpu_pkg::rsp_t rsp
);

  logic [3:0][7:0] regs_seen;
  logic [7:0]      rd_val;

  // destination register picked by the rd field of the executed byte
  assign regs_seen = {rsp.reg_d, rsp.reg_c, rsp.reg_b, rsp.reg_a};
  assign rd_val    = regs_seen[rsp.executed_word[3:2]];

  // no result pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // halt flag only on the halt encoding
  a_halt_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.halt_seen |-> rsp.executed_word == tcpu_pkg::HALT_WORD)
    else $error("halt flag on wrong word");

  // add, sub, load and shift-left-insert mirror their result into the top byte
  a_result_copy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.executed_word[7:4] == tcpu_pkg::OP_ADD ||
                  rsp.executed_word[7:4] == tcpu_pkg::OP_SUB ||
                  rsp.executed_word[7:4] == tcpu_pkg::OP_LOAD ||
                  rsp.executed_word[7:6] == tcpu_pkg::SLI_TOP)
    |-> rsp.result_byte == rd_val)
    else $error("result byte does not match destination register");

endmodule

bind tiny_8bit_cpu_step tcpu_checker u_chk (.*);

### tb/testbench.sv
module testbench;

  // run shape
  localparam int N_ITEMS        = 1500;
  localparam int IDLE_PCT       = 26;
  localparam int QUIET_FROM     = 700;   // stretch with no idling on either side
  localparam int QUIET_TO       = 900;
  localparam int HOLD_AT        = 400;   // receiver hold-off starts here
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_AT       = 1100;  // sender waits for every result here
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  // register indexes and encodings the block treats as no-ops
  localparam logic [1:0] R0 = 2'd0;
  localparam logic [1:0] R1 = 2'd1;
  localparam logic [1:0] R2 = 2'd2;
  localparam logic [1:0] R3 = 2'd3;
  localparam logic [1:0] SKIP_NONE = 2'b10;
  localparam logic [3:0] OP_NONE   = 4'h0;
  localparam logic [3:0] OP_SPARE  = 4'h6;
  localparam logic [1:0] SPARE_TOP = 2'b10;

  // mirror of the processor plus the queue of results it should produce
  class cpu_scoreboard;
    logic [7:0]     pc;
    logic [7:0]     regs [4];
    logic [7:0]     mem [tcpu_pkg::MEM_DEPTH];
    tcpu_pkg::rsp_t rsp_q [$];
    int             errors;

    function new();
      pc = '0;
      errors = 0;
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
    endfunction

    // predict the response of one accepted command
    function void note_cmd(tcpu_pkg::cmd_t c);
      tcpu_pkg::rsp_t e;
      logic [7:0]     w, vd, vs, r;
      logic [1:0]     rd, rs;
      e = '0;
      if (c.action == tcpu_pkg::ACT_WRITE) begin
        mem[c.load_addr] = c.load_data;
      end else begin
        w  = mem[pc];
        pc = pc + 8'd1;
        rd = w[3:2];
        rs = w[1:0];
        vd = regs[rd];
        vs = regs[rs];
        e.executed_word = w;
        case (w[7:4])
          tcpu_pkg::OP_ADD: begin
            r = vd + vs;
            regs[rd] = r;
            mem[tcpu_pkg::RESULT_ADDR] = r;
          end
          tcpu_pkg::OP_SUB: begin
            r = vd - vs;
            regs[rd] = r;
            mem[tcpu_pkg::RESULT_ADDR] = r;
          end
          tcpu_pkg::OP_LOAD: begin
            r = mem[vs];
            regs[rd] = r;
            mem[tcpu_pkg::RESULT_ADDR] = r;
          end
          tcpu_pkg::OP_STORE: begin
            mem[vs] = vd;
            mem[tcpu_pkg::RESULT_ADDR] = vd;
          end
          tcpu_pkg::OP_SKIP: begin
            if ((rs == tcpu_pkg::SKIP_Z && vd == 8'd0) ||
                (rs == tcpu_pkg::SKIP_NZ && vd != 8'd0)) begin
              pc = pc + 8'd1;
              mem[tcpu_pkg::RESULT_ADDR] = vd;
            end
          end
          tcpu_pkg::OP_JALR: begin
            r = pc;
            regs[rd] = r;
            pc = vs;
            mem[tcpu_pkg::RESULT_ADDR] = r;
          end
          default: begin
            if (w[7:6] == tcpu_pkg::SLI_TOP) begin
              r = {vd[3:0], w[5:4], w[1:0]};
              regs[rd] = r;
              mem[tcpu_pkg::RESULT_ADDR] = r;
            end else if (w == tcpu_pkg::HALT_WORD) begin
              e.halt_seen = 1'b1;
            end
          end
        endcase
      end
      e.pc_after    = pc;
      e.reg_a       = regs[0];
      e.reg_b       = regs[1];
      e.reg_c       = regs[2];
      e.reg_d       = regs[3];
      e.result_byte = mem[tcpu_pkg::RESULT_ADDR];
      rsp_q.push_back(e);
    endfunction

    function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_rsp(tcpu_pkg::rsp_t a);
      tcpu_pkg::rsp_t e;
      if (rsp_q.size() == 0) begin
        $error("response transaction with nothing expected: %0h", a);
        errors++;
        return;
      end
      e = rsp_q.pop_front();
      cmp_field("pc_after", e.pc_after, a.pc_after);
      cmp_field("executed_word", e.executed_word, a.executed_word);
      cmp_field("reg_a", e.reg_a, a.reg_a);
      cmp_field("reg_b", e.reg_b, a.reg_b);
      cmp_field("reg_c", e.reg_c, a.reg_c);
      cmp_field("reg_d", e.reg_d, a.reg_d);
      cmp_field("result_byte", e.result_byte, a.result_byte);
      cmp_field("halt_seen", 8'(e.halt_seen), 8'(a.halt_seen));
    endfunction

    function int pending();
      return rsp_q.size();
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           cmd_valid;
  logic           cmd_ready;
  tcpu_pkg::cmd_t cmd;
  logic           rsp_valid;
  logic           rsp_ready;
  tcpu_pkg::rsp_t rsp;

  cpu_scoreboard sb = new();

  int n_accepted = 0;   // command transactions accepted so far
  bit no_idle    = 1'b0;
  int stall_cnt  = 0;

  tiny_8bit_cpu_step i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // instruction byte builders
  function automatic logic [7:0] ins(logic [3:0] op, logic [1:0] rd, logic [1:0] rs);
    return {op, rd, rs};
  endfunction

  function automatic logic [7:0] sli(logic [1:0] rd, logic [3:0] imm);
    return {tcpu_pkg::SLI_TOP, imm[3:2], rd, imm[1:0]};
  endfunction

  // mostly meaningful instructions, with some no-ops and raw bytes
  function automatic logic [7:0] rand_instr();
    logic [1:0] rd, rs;
    rd = 2'($urandom_range(0, 3));
    rs = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 11))
      0:       return ins(tcpu_pkg::OP_ADD, rd, rs);
      1:       return ins(tcpu_pkg::OP_SUB, rd, rs);
      2:       return ins(tcpu_pkg::OP_LOAD, rd, rs);
      3:       return ins(tcpu_pkg::OP_STORE, rd, rs);
      4, 5:    return ins(tcpu_pkg::OP_SKIP, rd, rs);
      6:       return ins(tcpu_pkg::OP_JALR, rd, rs);
      7, 8:    return sli(rd, 4'($urandom_range(0, 15)));
      9: begin
        case ($urandom_range(0, 3))
          0:       return tcpu_pkg::HALT_WORD;
          1:       return ins(OP_NONE, rd, rs);
          2:       return ins(OP_SPARE, rd, rs);
          default: return {SPARE_TOP, 6'($urandom_range(0, 63))};
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic tcpu_pkg::cmd_t mk_write(logic [7:0] addr, logic [7:0] data);
    tcpu_pkg::cmd_t c;
    c.action    = tcpu_pkg::ACT_WRITE;
    c.load_addr = addr;
    c.load_data = data;
    return c;
  endfunction

  // address and data are ignored on execute, but keep them moving
  function automatic tcpu_pkg::cmd_t mk_exec();
    tcpu_pkg::cmd_t c;
    c.action    = tcpu_pkg::ACT_EXEC;
    c.load_addr = 8'($urandom_range(0, 255));
    c.load_data = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // offer one command and hold it until the handshake completes
  task automatic send_cmd(tcpu_pkg::cmd_t c);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        @(negedge clk);
        cmd_valid <= 1'b0;
      end
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
    sb.note_cmd(c);
    n_accepted++;
  endtask

  task automatic stop_cmd();
    @(negedge clk);
    cmd_valid <= 1'b0;
  endtask

  task automatic wait_all_rsp();
    stop_cmd();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // receiver: random back-pressure, one long hold-off, a quiet stretch
  initial begin
    bit held;
    held = 1'b0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_cnt > 0) begin
        rsp_ready <= 1'b0;
        stall_cnt--;
      end else if (!held && n_accepted >= HOLD_AT) begin
        // hold off long enough that the block backs up and stalls its input
        held = 1'b1;
        stall_cnt = HOLD_CYCLES - 1;
        rsp_ready <= 1'b0;
      end else if (no_idle || rst) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // every accepted response goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_rsp(rsp);
  end

  // watchdog on cycles without any transaction
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main stimulus
  initial begin
    logic [7:0] prog_addr [$];
    logic [7:0] prog_word [$];
    logic [7:0] base;
    int         len, extra, kind;
    bit         drained;

    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    drained   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed program: wraps, both skips taken, the zero skip not taken, store to
    // the result byte, load back, halt, an unused skip flavor and a jump with link
    prog_addr = '{8'd255, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd7,
                  8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14};
    prog_word = '{8'hAA, sli(R0, 4'hF), sli(R0, 4'hF), sli(R1, 4'h1),
                  ins(tcpu_pkg::OP_ADD, R0, R1),     // 0xff + 1 wraps to zero
                  ins(tcpu_pkg::OP_SKIP, R0, tcpu_pkg::SKIP_Z),  // taken
                  ins(tcpu_pkg::OP_SUB, R0, R1),     // 0 - 1 borrows to 0xff
                  ins(tcpu_pkg::OP_SKIP, R0, tcpu_pkg::SKIP_NZ), // taken
                  ins(tcpu_pkg::OP_STORE, R1, R0),   // store into the result byte
                  ins(tcpu_pkg::OP_LOAD, R2, R0),
                  ins(tcpu_pkg::OP_SKIP, R0, tcpu_pkg::SKIP_Z),  // not taken
                  tcpu_pkg::HALT_WORD,
                  ins(tcpu_pkg::OP_SKIP, R0, SKIP_NONE),
                  ins(tcpu_pkg::OP_JALR, R3, R1)};
    foreach (prog_addr[i]) send_cmd(mk_write(prog_addr[i], prog_word[i]));
    repeat (13) send_cmd(mk_exec());
    wait_all_rsp();

    // random part: mostly short programs written at the current pc and run
    while (n_accepted < N_ITEMS) begin
      if (!drained && n_accepted >= DRAIN_AT) begin
        wait_all_rsp();
        drained = 1'b1;
      end
      no_idle = (n_accepted >= QUIET_FROM && n_accepted < QUIET_TO);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len   = $urandom_range(1, 6);
        extra = $urandom_range(0, 2);
        base  = sb.pc;
        for (int i = 0; i < len; i++) send_cmd(mk_write(base + 8'(i), rand_instr()));
        repeat (len + extra) send_cmd(mk_exec());
      end else if (kind < 85) begin
        send_cmd(mk_write(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
      end else begin
        send_cmd(mk_exec());
      end
    end
    no_idle = 1'b0;

    wait_all_rsp();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### files.f
src/tcpu_pkg.sv
src/tcpu_mem.sv
src/tcpu_exec.sv
src/tiny_8bit_cpu_step.sv
src/tcpu_checker.sv
tb/testbench.sv
